>>> hdl/ilc_pkg.sv
// ----------------------------------------------------------------------------
// ilc_pkg
// Shared types and codes of the indexed list with compaction.
// ----------------------------------------------------------------------------
`default_nettype none

package ilc_pkg;

   localparam int FUNC_WIDTH   = 2;
   localparam int INDEX_WIDTH  = 8;
   localparam int VALUE_WIDTH  = 32;
   localparam int LENGTH_WIDTH = 7;
   localparam int STATUS_WIDTH = 2;

   localparam logic [FUNC_WIDTH-1:0] OP_APPEND = 2'd0;
   localparam logic [FUNC_WIDTH-1:0] OP_SET    = 2'd1;
   localparam logic [FUNC_WIDTH-1:0] OP_GET    = 2'd2;
   localparam logic [FUNC_WIDTH-1:0] OP_DELETE = 2'd3;

   localparam logic [STATUS_WIDTH-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL      = 2'd2;

   // per-cell enables, load wins over shift
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

>>> hdl/ilc_if.sv
// ----------------------------------------------------------------------------
// ilc_req_if / ilc_rsp_if
// Valid/ready channels for requests and results of the list.
// ----------------------------------------------------------------------------
`default_nettype none

interface ilc_req_if;
   logic                             valid;
   logic                             ready;
   logic [ilc_pkg::FUNC_WIDTH-1:0]   func;
   logic [ilc_pkg::INDEX_WIDTH-1:0]  index;
   logic [ilc_pkg::VALUE_WIDTH-1:0]  item_value;

   modport source (output valid, output func, output index, output item_value,
                   input ready);
   modport sink (input valid, input func, input index, input item_value,
                 output ready);
endinterface

interface ilc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ilc_pkg::VALUE_WIDTH-1:0]   read_value;
   logic [ilc_pkg::LENGTH_WIDTH-1:0]  list_length;
   logic [ilc_pkg::STATUS_WIDTH-1:0]  status;

   modport source (output valid, output read_value, output list_length,
                   output status, input ready);
   modport sink (input valid, input read_value, input list_length,
                 input status, output ready);
endinterface

`default_nettype wire

>>> hdl/ilc_cell.sv
// ----------------------------------------------------------------------------
// ilc_cell
// One list slot: loads a new word or takes its upper neighbour's word.
// ----------------------------------------------------------------------------
`default_nettype none

module ilc_cell #(
   parameter int WIDTH = 32
) (
   input  wire                        clock,
   input  wire ilc_pkg::cell_ctrl_type ctrl,
   input  wire [WIDTH-1:0]            load_word,
   input  wire [WIDTH-1:0]            next_word,
   output logic [WIDTH-1:0]           word
);

   logic [WIDTH-1:0] word_ff;
   logic [WIDTH-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (ctrl.load) begin
         word_in = load_word;
      end else if (ctrl.shift) begin
         word_in = next_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

`default_nettype wire

>>> hdl/indexed_list_with_compaction_unit.sv
// ----------------------------------------------------------------------------
// indexed_list_with_compaction_unit
// Fixed-capacity ordered list held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Requests arrive on req_chan (func, index, item_value) and each gives one
// result on rsp_chan (read_value, list_length, status). Append stores at the
// tail, set overwrites an entry, get reads one, delete removes one and the
// cell at its index and every cell above take their upper neighbour's word
// in the same clock.
// The result is registered and shows in the cycle after acceptance.
// Throughput: one request per cycle while results are taken; the length
// register and the cell row are updated at the accepting edge.
// A stalled result holds in the output register; a new request is accepted
// in the cycle the waiting result is taken.
// Reset clears the length and the result valid; cell contents are not
// cleared and an entry is only read after it has been written.
// For set, get and delete, status reports a bad index when the index is not
// below the length, full on an append at capacity; neither changes the list.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_with_compaction_unit #(
   parameter int CAPACITY   = 64,
   parameter int ITEM_WIDTH = 32
) (
   input wire        clock,
   input wire        reset,
   ilc_req_if.sink   req_chan,
   ilc_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > ilc_pkg::INDEX_WIDTH) ? CNT_W : ilc_pkg::INDEX_WIDTH) + 1;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [ilc_pkg::VALUE_WIDTH-1:0]   read_value_ff;
   logic [ilc_pkg::VALUE_WIDTH-1:0]   read_value_in;
   logic [ilc_pkg::LENGTH_WIDTH-1:0]  list_length_ff;
   logic [ilc_pkg::LENGTH_WIDTH-1:0]  list_length_in;
   logic [ilc_pkg::STATUS_WIDTH-1:0]  status_ff;
   logic [ilc_pkg::STATUS_WIDTH-1:0]  status_in;

   logic                  accept;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      count_ext;
   logic                  is_full;
   logic                  bad_index;
   logic                  do_append;
   logic                  do_set;
   logic                  do_delete;
   logic [ITEM_WIDTH-1:0] load_word;
   logic [ITEM_WIDTH-1:0] get_word;

   logic [ITEM_WIDTH-1:0]  cell_word [CAPACITY];
   ilc_pkg::cell_ctrl_type cell_ctrl [CAPACITY];

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign pos_ext   = CMP_W'(req_chan.index);
   assign count_ext = CMP_W'(count_ff);
   assign is_full   = (count_ext == CMP_W'(CAPACITY));
   assign bad_index = (pos_ext >= count_ext);
   assign load_word = ITEM_WIDTH'(req_chan.item_value);

   assign do_append = accept && (req_chan.func == ilc_pkg::OP_APPEND) && !is_full;
   assign do_set    = accept && (req_chan.func == ilc_pkg::OP_SET) && !bad_index;
   assign do_delete = accept && (req_chan.func == ilc_pkg::OP_DELETE) && !bad_index;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ITEM_WIDTH-1:0] next_word;

      // the slot vacated at the tail of a delete is cleared
      if (i == CAPACITY - 1) begin : g_top
         assign next_word = '0;
      end else begin : g_mid
         assign next_word = (count_ext == CMP_W'(i + 1)) ? '0 : cell_word[i+1];
      end

      assign cell_ctrl[i].load  = (do_append && (count_ext == CMP_W'(i)))
                               || (do_set && (pos_ext == CMP_W'(i)));
      assign cell_ctrl[i].shift = do_delete && (CMP_W'(i) >= pos_ext);

      ilc_cell #(
         .WIDTH (ITEM_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl[i]),
         .load_word (load_word),
         .next_word (next_word),
         .word      (cell_word[i])
      );
   end

   // and-or read bus across the row
   always_comb begin
      get_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (pos_ext == CMP_W'(i)) begin
            get_word = get_word | cell_word[i];
         end
      end
   end

   always_comb begin
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      read_value_in  = read_value_ff;
      list_length_in = list_length_ff;
      status_in      = status_ff;
      if (do_append) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_delete) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (accept) begin
         rsp_valid_in   = 1'b1;
         read_value_in  = '0;
         status_in      = ilc_pkg::ST_OK;
         list_length_in = ilc_pkg::LENGTH_WIDTH'(count_in);
         case (req_chan.func)
            ilc_pkg::OP_APPEND: begin
               if (is_full) begin
                  status_in = ilc_pkg::ST_FULL;
               end
            end
            ilc_pkg::OP_GET: begin
               if (bad_index) begin
                  status_in = ilc_pkg::ST_BAD_INDEX;
               end else begin
                  read_value_in = ilc_pkg::VALUE_WIDTH'(get_word);
               end
            end
            default: begin
               if (bad_index) begin
                  status_in = ilc_pkg::ST_BAD_INDEX;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      read_value_ff  <= read_value_in;
      list_length_ff <= list_length_in;
      status_ff      <= status_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_value  = read_value_ff;
   assign rsp_chan.list_length = list_length_ff;
   assign rsp_chan.status      = status_ff;

endmodule

`default_nettype wire

>>> hdl/ilc_checker.sv
// ----------------------------------------------------------------------------
// ilc_checker
// Port-level checks on the list unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ilc_checker #(
   parameter int CAPACITY = 64
) (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_valid,
   input wire                              req_ready,
   input wire                              rsp_valid,
   input wire                              rsp_ready,
   input wire [ilc_pkg::VALUE_WIDTH-1:0]   read_value,
   input wire [ilc_pkg::LENGTH_WIDTH-1:0]  list_length,
   input wire [ilc_pkg::STATUS_WIDTH-1:0]  status
);

   // every accepted transaction gives a result in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("no result after accepted request");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(read_value)
         && $stable(list_length) && $stable(status)))
      else $error("stalled result changed");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (status != ilc_pkg::ST_OK)) |-> (read_value == '0))
      else $error("read value on failed request");

   a_full_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (status == ilc_pkg::ST_FULL))
         |-> (list_length == ilc_pkg::LENGTH_WIDTH'(CAPACITY)))
      else $error("full status with list not at capacity");

endmodule

bind indexed_list_with_compaction_unit ilc_checker #(
   .CAPACITY (CAPACITY)
) u_ilc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .read_value  (rsp_chan.read_value),
   .list_length (rsp_chan.list_length),
   .status      (rsp_chan.status)
);

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the indexed list with compaction.
// ----------------------------------------------------------------------------
// A shadow copy of the list predicts every result from the accepted requests.
// Each accepted result is compared with the oldest prediction. Directed
// requests cover the boundaries first. Random phases follow: mixed traffic,
// filling to capacity, draining by deletes, and raw noise. The result side
// idles at random throughout, the request side in most phases.
// ----------------------------------------------------------------------------

module testbench;

   localparam int LIST_CAPACITY = 64;
   localparam int ITEM_BITS     = 32;
   localparam int RANDOM_ITEMS  = 900;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 600000;

   typedef logic [ilc_pkg::FUNC_WIDTH-1:0]  func_type;
   typedef logic [ilc_pkg::INDEX_WIDTH-1:0] index_type;
   typedef logic [ilc_pkg::VALUE_WIDTH-1:0] value_type;

   typedef struct {
      logic [ilc_pkg::VALUE_WIDTH-1:0]  read_value;
      logic [ilc_pkg::LENGTH_WIDTH-1:0] list_length;
      logic [ilc_pkg::STATUS_WIDTH-1:0] status;
   } list_result_type;

   class list_shadow;
      logic [ITEM_BITS-1:0] words [LIST_CAPACITY];
      int unsigned          length;
      list_result_type      pending_results [$];
      int unsigned          mismatches;
      int unsigned          results_seen;
      int unsigned          refused_appends;
      int unsigned          bad_indexes;
      int unsigned          peak_length;
      int unsigned          op_counts [4];

      function new();
         length          = 0;
         mismatches      = 0;
         results_seen    = 0;
         refused_appends = 0;
         bad_indexes     = 0;
         peak_length     = 0;
         foreach (op_counts[i]) op_counts[i] = 0;
         foreach (words[i]) words[i] = '0;
      endfunction

      // apply one accepted request to the shadow list and queue its result
      function void record_request(func_type func,
                                   index_type index,
                                   value_type item_value);
         list_result_type res;
         int unsigned     pos;
         int unsigned     i;
         res.read_value = '0;
         res.status     = ilc_pkg::ST_OK;
         pos            = 32'(index);
         op_counts[func]++;
         if (func == ilc_pkg::OP_APPEND) begin
            if (length >= LIST_CAPACITY) begin
               res.status = ilc_pkg::ST_FULL;
               refused_appends++;
            end else begin
               words[length] = item_value[ITEM_BITS-1:0];
               length++;
            end
         end else if (pos >= length) begin
            res.status = ilc_pkg::ST_BAD_INDEX;
            bad_indexes++;
         end else if (func == ilc_pkg::OP_SET) begin
            words[pos] = item_value[ITEM_BITS-1:0];
         end else if (func == ilc_pkg::OP_GET) begin
            res.read_value = words[pos];
         end else begin
            // compaction: everything above the hole moves down one place
            for (i = pos; i + 1 < length; i++) words[i] = words[i+1];
            words[length-1] = '0;
            length--;
         end
         if (length > peak_length) peak_length = length;
         res.list_length = length[ilc_pkg::LENGTH_WIDTH-1:0];
         pending_results.push_back(res);
      endfunction

      function void compare_result(list_result_type got);
         list_result_type want;
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: value %h length %0d status %0d",
                        got.read_value, got.list_length, got.status);
            return;
         end
         want = pending_results.pop_front();
         if (got.read_value !== want.read_value || got.list_length !== want.list_length
             || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch at result %0d: expected value %h length %0d ",
                         "status %0d, got value %h length %0d status %0d"},
                        results_seen, want.read_value, want.list_length, want.status,
                        got.read_value, got.list_length, got.status);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ilc_req_if req_chan ();
   ilc_rsp_if rsp_chan ();

   indexed_list_with_compaction_unit #(
      .CAPACITY   (LIST_CAPACITY),
      .ITEM_WIDTH (ITEM_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   list_shadow      shadow;
   list_result_type observed_result;
   int unsigned     cycle_count = 0;
   int unsigned     items_sent  = 0;
   int unsigned     stim_length = 0;
   bit              no_idle     = 1'b0;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still awaited", cycle_count,
                  shadow.pending_results.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // result first, so a result and a new transaction at one edge stay in order
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            observed_result.read_value  = rsp_chan.read_value;
            observed_result.list_length = rsp_chan.list_length;
            observed_result.status      = rsp_chan.status;
            shadow.compare_result(observed_result);
         end
         if (req_chan.valid && req_chan.ready)
            shadow.record_request(req_chan.func, req_chan.index, req_chan.item_value);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // mostly valid positions, some at the boundary, some anywhere
   function automatic index_type pick_index();
      int r;
      r = $urandom_range(0, 99);
      if (stim_length > 0 && r < 85) return index_type'($urandom_range(0, stim_length - 1));
      if (r < 93) return index_type'(stim_length);
      return index_type'($urandom_range(0, 255));
   endfunction

   function automatic func_type pick_func();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return ilc_pkg::OP_APPEND;
      if (r < 50) return ilc_pkg::OP_SET;
      if (r < 75) return ilc_pkg::OP_GET;
      return ilc_pkg::OP_DELETE;
   endfunction

   task automatic put_request(input func_type func,
                              input index_type index,
                              input value_type item_value);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.func       <= func;
      req_chan.index      <= index;
      req_chan.item_value <= item_value;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (func == ilc_pkg::OP_APPEND) begin
         if (stim_length < LIST_CAPACITY) stim_length++;
      end else if (func == ilc_pkg::OP_DELETE && index < stim_length) begin
         stim_length--;
      end
      items_sent++;
   endtask

   // result side: runs of ready with random stalls between them
   initial begin
      int run;
      int gap;
      rsp_chan.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
         rsp_chan.ready <= 1'b1;
         repeat (run) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin
      int unsigned directed_items;
      int          scenario;
      shadow              = new();
      req_chan.valid      = 1'b0;
      req_chan.func       = ilc_pkg::OP_APPEND;
      req_chan.index      = '0;
      req_chan.item_value = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty list: every indexed operation is refused
      put_request(ilc_pkg::OP_GET, 8'h00, $urandom);
      put_request(ilc_pkg::OP_DELETE, 8'h00, $urandom);
      put_request(ilc_pkg::OP_SET, 8'hFF, 32'hFFFF_FFFF);
      put_request(ilc_pkg::OP_APPEND, 8'hFF, 32'h0000_0000);
      put_request(ilc_pkg::OP_APPEND, 8'h00, 32'hFFFF_FFFF);
      put_request(ilc_pkg::OP_APPEND, 8'h55, 32'hA5A5_A5A5);
      put_request(ilc_pkg::OP_GET, 8'h00, 32'hFFFF_FFFF);
      put_request(ilc_pkg::OP_GET, 8'h01, $urandom);
      put_request(ilc_pkg::OP_GET, 8'h02, $urandom);
      put_request(ilc_pkg::OP_GET, 8'h03, $urandom);
      put_request(ilc_pkg::OP_GET, 8'hFF, $urandom);
      put_request(ilc_pkg::OP_SET, 8'h01, 32'h5A5A_5A5A);
      put_request(ilc_pkg::OP_SET, 8'h03, 32'h1234_5678);
      put_request(ilc_pkg::OP_GET, 8'h01, $urandom);
      // delete at the head, then at the tail
      put_request(ilc_pkg::OP_DELETE, 8'h00, $urandom);
      put_request(ilc_pkg::OP_GET, 8'h00, $urandom);
      put_request(ilc_pkg::OP_GET, 8'h01, $urandom);
      put_request(ilc_pkg::OP_DELETE, 8'h01, $urandom);
      put_request(ilc_pkg::OP_DELETE, 8'h01, $urandom);
      put_request(ilc_pkg::OP_GET, 8'h00, $urandom);
      put_request(ilc_pkg::OP_DELETE, 8'h00, $urandom);
      put_request(ilc_pkg::OP_APPEND, 8'h00, 32'h0000_0001);
      put_request(ilc_pkg::OP_APPEND, 8'h80, 32'h8000_0000);
      put_request(ilc_pkg::OP_GET, 8'h01, $urandom);
      directed_items = items_sent;

      while (items_sent < directed_items + RANDOM_ITEMS) begin
         no_idle  = ($urandom_range(0, 4) == 0);
         scenario = $urandom_range(0, 9);
         if (scenario < 5) begin
            repeat ($urandom_range(10, 40)) put_request(pick_func(), pick_index(), $urandom);
         end else if (scenario < 7) begin
            // fill to capacity, then push past it
            while (stim_length < LIST_CAPACITY) begin
               if ($urandom_range(0, 9) == 0)
                  put_request(ilc_pkg::OP_GET, pick_index(), $urandom);
               else
                  put_request(ilc_pkg::OP_APPEND, index_type'($urandom_range(0, 255)),
                              $urandom);
            end
            repeat ($urandom_range(1, 3))
               put_request(ilc_pkg::OP_APPEND, index_type'($urandom_range(0, 255)),
                           $urandom);
            put_request(ilc_pkg::OP_SET, index_type'(LIST_CAPACITY - 1), $urandom);
            put_request(ilc_pkg::OP_GET, index_type'(LIST_CAPACITY - 1), $urandom);
            put_request(ilc_pkg::OP_GET, index_type'(LIST_CAPACITY), $urandom);
         end else if (scenario < 9) begin
            // drain by deletes at random positions
            while (stim_length > 0) begin
               if ($urandom_range(0, 3) == 0)
                  put_request(ilc_pkg::OP_GET, pick_index(), $urandom);
               else
                  put_request(ilc_pkg::OP_DELETE,
                              index_type'($urandom_range(0, stim_length - 1)), $urandom);
            end
            put_request(ilc_pkg::OP_DELETE, index_type'($urandom_range(0, 255)), $urandom);
         end else begin
            repeat ($urandom_range(5, 15))
               put_request(func_type'($urandom_range(0, 3)),
                           index_type'($urandom_range(0, 255)), $urandom);
         end
      end
      req_chan.valid <= 1'b0;

      while (shadow.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      shadow.mismatches += shadow.pending_results.size();

      $display("ran %0d requests (append %0d, set %0d, get %0d, delete %0d)",
               items_sent, shadow.op_counts[ilc_pkg::OP_APPEND],
               shadow.op_counts[ilc_pkg::OP_SET], shadow.op_counts[ilc_pkg::OP_GET],
               shadow.op_counts[ilc_pkg::OP_DELETE]);
      $display("%0d results checked, refused appends %0d, bad indexes %0d, peak length %0d",
               shadow.results_seen, shadow.refused_appends, shadow.bad_indexes,
               shadow.peak_length);
      if (shadow.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", shadow.mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
